/* hdl/lqpm_pkg.sv */
// shared types and codes of the linked queue pool manager
package lqpm_pkg;

  localparam int IDX_W = 5;
  localparam int OP_W  = 3;
  localparam int ST_W  = 2;

  // command codes
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
  localparam logic [OP_W-1:0] OP_ENQ    = 3'd2;
  localparam logic [OP_W-1:0] OP_DEQ    = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic             queue_nonempty;
    logic [IDX_W-1:0] tail_entry;
    logic [IDX_W-1:0] target_entry;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] result_entry;
    logic             new_queue_nonempty;
    logic [IDX_W-1:0] new_tail_entry;
  } out_t;

endpackage

/* hdl/linked_queue_pool_manager.sv */
// top level of the linked queue pool manager: command sequencer around the link table
// steps to the result beat, held while the output register is full: free, enqueue to an
// empty queue, unknown codes and errors found at accept end there; allocate, peek, dequeue
// and enqueue read one link, enqueue then writes twice, dequeue reads the head's link if
// not the last; remove reads up to POOL_ENTRIES links, plus a found entry's if not sole
// throughput: one command at a time, the next is taken the cycle after its result is loaded
// reset: in_ready stays low during a pass over the table that writes i+1 into entry i
module linked_queue_pool_manager #(
  parameter int POOL_ENTRIES = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lqpm_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lqpm_pkg::out_t  out_data
);

  localparam int IDX_W = lqpm_pkg::IDX_W;
  // link width holds every index plus the "none" code
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam int AW = $clog2(POOL_ENTRIES);
  // compare width covers both link values and 5-bit command indexes
  localparam int CW = (LW > IDX_W) ? LW : IDX_W;
  localparam logic [LW-1:0] NONE_LINK = LW'(POOL_ENTRIES);
  localparam logic [CW-1:0] POOL_CW   = CW'(POOL_ENTRIES);
  localparam logic [AW-1:0] LAST_IDX  = AW'(POOL_ENTRIES - 1);

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,  // rebuilding the link table after reset
    S_IDLE  = 7'b0000010,  // taking a command
    S_LINK  = 7'b0000100,  // first link read is back
    S_WR2   = 7'b0001000,  // second write of an enqueue
    S_WALK  = 7'b0010000,  // remove: following links
    S_FETCH = 7'b0100000,  // link of the unlinked entry is back
    S_DONE  = 7'b1000000   // result held until the output register frees up
  } state_t;

  state_t          state_r, state_nxt;
  logic [LW-1:0]   fh_r, fh_nxt;        // free list head
  logic [AW-1:0]   init_r, init_nxt;    // rebuild pointer
  logic [AW-1:0]   aux_r, aux_nxt;      // walk position, or the head on dequeue
  logic [AW-1:0]   cnt_r, cnt_nxt;      // walk step count
  lqpm_pkg::in_t   cmd_r, cmd_nxt;
  lqpm_pkg::in_t   cmd;
  lqpm_pkg::out_t  res_r, res_nxt;
  lqpm_pkg::out_t  load_data;
  logic            fin;
  logic            load;
  logic            slot_free;

  // link table port
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [LW-1:0]   mem_wdata;
  logic [LW-1:0]   rd;

  logic            tail_ok, tgt_ok, fh_ok, rd_ok;
  logic            q_op;

  assign in_ready = (state_r == S_IDLE);

  // in idle the command comes straight from the port, later from its register
  assign cmd = (state_r == S_IDLE) ? in_data : cmd_r;

  assign tail_ok = CW'(cmd.tail_entry) < POOL_CW;
  assign tgt_ok  = CW'(cmd.target_entry) < POOL_CW;
  assign fh_ok   = CW'(fh_r) < POOL_CW;
  assign rd_ok   = CW'(rd) < POOL_CW;
  assign q_op    = (cmd.opcode == lqpm_pkg::OP_ENQ) || (cmd.opcode == lqpm_pkg::OP_DEQ) ||
                   (cmd.opcode == lqpm_pkg::OP_REMOVE) || (cmd.opcode == lqpm_pkg::OP_PEEK);

  // reads and writes of the table never share a cycle, so no forwarding is needed:
  // each read is issued only after the writes of the previous step have landed
  always_comb begin
    state_nxt = state_r;
    fh_nxt    = fh_r;
    init_nxt  = init_r;
    aux_nxt   = aux_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    fin       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    // default answer leaves the queue as given
    res_nxt.status             = lqpm_pkg::ST_OK;
    res_nxt.result_entry       = '0;
    res_nxt.new_queue_nonempty = cmd.queue_nonempty;
    res_nxt.new_tail_entry     = cmd.queue_nonempty ? cmd.tail_entry : '0;

    case (state_r)
      S_INIT: begin
        // entry i links to i+1, the last one to none
        mem_we    = 1'b1;
        mem_waddr = init_r;
        mem_wdata = LW'(init_r) + LW'(1);
        if (init_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          init_nxt = init_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data;
          if (cmd.queue_nonempty && !tail_ok && q_op) begin
            fin            = 1'b1;
            res_nxt.status = lqpm_pkg::ST_NOT_FOUND;
          end else begin
            case (cmd.opcode)
              lqpm_pkg::OP_ALLOC: begin
                if (!fh_ok) begin
                  fin            = 1'b1;
                  res_nxt.status = lqpm_pkg::ST_EXHAUSTED;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = AW'(fh_r);
                  state_nxt = S_LINK;
                end
              end
              lqpm_pkg::OP_FREE: begin
                fin = 1'b1;
                if (!tgt_ok) begin
                  res_nxt.status = lqpm_pkg::ST_NOT_FOUND;
                end else begin
                  // push onto the free list
                  mem_we    = 1'b1;
                  mem_waddr = AW'(cmd.target_entry);
                  mem_wdata = fh_r;
                  fh_nxt    = LW'(cmd.target_entry);
                end
              end
              lqpm_pkg::OP_ENQ: begin
                if (!tgt_ok) begin
                  fin            = 1'b1;
                  res_nxt.status = lqpm_pkg::ST_NOT_FOUND;
                end else if (!cmd.queue_nonempty) begin
                  // single entry queue links to itself
                  fin                        = 1'b1;
                  mem_we                     = 1'b1;
                  mem_waddr                  = AW'(cmd.target_entry);
                  mem_wdata                  = LW'(cmd.target_entry);
                  res_nxt.new_queue_nonempty = 1'b1;
                  res_nxt.new_tail_entry     = cmd.target_entry;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = AW'(cmd.tail_entry);
                  state_nxt = S_LINK;
                end
              end
              lqpm_pkg::OP_REMOVE: begin
                if (!tgt_ok) begin
                  fin            = 1'b1;
                  res_nxt.status = lqpm_pkg::ST_NOT_FOUND;
                end else if (!cmd.queue_nonempty) begin
                  fin            = 1'b1;
                  res_nxt.status = lqpm_pkg::ST_EMPTY;
                end else begin
                  // walk starts at the tail
                  mem_re    = 1'b1;
                  mem_raddr = AW'(cmd.tail_entry);
                  aux_nxt   = AW'(cmd.tail_entry);
                  cnt_nxt   = '0;
                  state_nxt = S_WALK;
                end
              end
              lqpm_pkg::OP_DEQ, lqpm_pkg::OP_PEEK: begin
                if (!cmd.queue_nonempty) begin
                  fin            = 1'b1;
                  res_nxt.status = lqpm_pkg::ST_EMPTY;
                end else begin
                  // the tail links to the head
                  mem_re    = 1'b1;
                  mem_raddr = AW'(cmd.tail_entry);
                  state_nxt = S_LINK;
                end
              end
              default: begin
                // unknown code: nothing changes
                fin = 1'b1;
              end
            endcase
          end
        end
      end

      S_LINK: begin
        case (cmd.opcode)
          lqpm_pkg::OP_ALLOC: begin
            // pop the free head and clear its link
            fin                  = 1'b1;
            res_nxt.result_entry = IDX_W'(fh_r);
            fh_nxt               = rd;
            mem_we               = 1'b1;
            mem_waddr            = AW'(fh_r);
            mem_wdata            = NONE_LINK;
          end
          lqpm_pkg::OP_ENQ: begin
            // new entry takes over the tail's link to the head
            mem_we    = 1'b1;
            mem_waddr = AW'(cmd.target_entry);
            mem_wdata = rd;
            state_nxt = S_WR2;
          end
          lqpm_pkg::OP_DEQ, lqpm_pkg::OP_PEEK: begin
            if (!rd_ok) begin
              // broken queue
              fin            = 1'b1;
              res_nxt.status = lqpm_pkg::ST_EMPTY;
            end else begin
              res_nxt.result_entry = IDX_W'(rd);
              if (cmd.opcode == lqpm_pkg::OP_PEEK) begin
                fin = 1'b1;
              end else if (CW'(rd) == CW'(cmd.tail_entry)) begin
                // last entry leaves, queue becomes empty
                fin                        = 1'b1;
                res_nxt.new_queue_nonempty = 1'b0;
                res_nxt.new_tail_entry     = '0;
              end else begin
                aux_nxt   = AW'(rd);
                mem_re    = 1'b1;
                mem_raddr = AW'(rd);
                state_nxt = S_FETCH;
              end
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_WR2: begin
        mem_we                     = 1'b1;
        mem_waddr                  = AW'(cmd.tail_entry);
        mem_wdata                  = LW'(cmd.target_entry);
        fin                        = 1'b1;
        res_nxt.new_queue_nonempty = 1'b1;
        res_nxt.new_tail_entry     = cmd.target_entry;
      end

      S_WALK: begin
        // rd is the link of aux_r
        if (!rd_ok) begin
          fin            = 1'b1;
          res_nxt.status = lqpm_pkg::ST_NOT_FOUND;
        end else if (CW'(rd) == CW'(cmd.target_entry)) begin
          if ((cmd.target_entry == cmd.tail_entry) &&
              (CW'(aux_r) == CW'(cmd.tail_entry))) begin
            // the only entry goes away
            fin                        = 1'b1;
            res_nxt.result_entry       = cmd.target_entry;
            res_nxt.new_queue_nonempty = 1'b0;
            res_nxt.new_tail_entry     = '0;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(cmd.target_entry);
            state_nxt = S_FETCH;
          end
        end else if ((CW'(rd) == CW'(cmd.tail_entry)) || (cnt_r == LAST_IDX)) begin
          // back at the tail, or out of steps
          fin            = 1'b1;
          res_nxt.status = lqpm_pkg::ST_NOT_FOUND;
        end else begin
          aux_nxt   = AW'(rd);
          cnt_nxt   = cnt_r + AW'(1);
          mem_re    = 1'b1;
          mem_raddr = AW'(rd);
        end
      end

      S_FETCH: begin
        fin    = 1'b1;
        mem_we = 1'b1;
        if (cmd.opcode == lqpm_pkg::OP_DEQ) begin
          // tail now links past the old head
          mem_waddr            = AW'(cmd.tail_entry);
          mem_wdata            = rd;
          res_nxt.result_entry = IDX_W'(aux_r);
        end else begin
          // predecessor links past the removed entry
          mem_waddr            = aux_r;
          mem_wdata            = rd;
          res_nxt.result_entry = cmd.target_entry;
          if (cmd.target_entry == cmd.tail_entry) begin
            res_nxt.new_tail_entry = IDX_W'(aux_r);
          end
        end
      end

      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase

    // a finished command goes to the output register, or waits when it is full
    if (fin) begin
      state_nxt = slot_free ? S_IDLE : S_DONE;
    end
  end

  assign load      = slot_free && (fin || (state_r == S_DONE));
  assign load_data = (state_r == S_DONE) ? res_r : res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      fh_r    <= '0;
      init_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fh_r    <= fh_nxt;
      init_r  <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    aux_r <= aux_nxt;
    cnt_r <= cnt_nxt;
    if (fin) begin
      res_r <= res_nxt;
    end
  end

  lqpm_link_ram #(
    .DEPTH (POOL_ENTRIES),
    .AW    (AW),
    .DW    (LW)
  ) u_link_ram (
    .clk       (clk),
    .we        (mem_we),
    .waddr     (mem_waddr),
    .wdata     (mem_wdata),
    .re        (mem_re),
    .raddr     (mem_raddr),
    .rd_data_r (rd)
  );

  lqpm_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_data (load_data),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // table is never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("link table read and write in the same cycle");

  // every write lands inside the pool
  a_waddr_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CW'(mem_waddr) < POOL_CW))
    else $error("link table write outside the pool");

  // free head is an entry or the none code
  a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_INIT) |-> (fh_r <= NONE_LINK))
    else $error("free head beyond the none code");

  // a held result stays held while the output register is full
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && !slot_free) |=> (state_r == S_DONE) && $stable(res_r))
    else $error("held result lost");

endmodule

/* hdl/lqpm_link_ram.sv */
// next-link table: one write port, one read port, registered read data
module lqpm_link_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rd_data_r
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

endmodule

/* hdl/lqpm_out_stage.sv */
// result output register, refilled in the cycle its beat is taken
module lqpm_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  lqpm_pkg::out_t    load_data,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output lqpm_pkg::out_t    out_data
);

  logic           valid_r;
  lqpm_pkg::out_t data_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule
